FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the indexed front list store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/ifls_pkg.sv
// Operation and status codes plus controller/datapath interface types.
package ifls_pkg;

  localparam logic [2:0] OP_SEARCH = 3'd0;
  localparam logic [2:0] OP_GET    = 3'd1;
  localparam logic [2:0] OP_SET    = 3'd2;
  localparam logic [2:0] OP_PUSH   = 3'd3;
  localparam logic [2:0] OP_POP    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       scan_step;
    logic       get_rd;
    logic       set_wr;
    logic       push;
    logic       pop;
    logic       finish;
    logic       res_found;
    logic       res_read;
    logic [1:0] res_status;
  } ifls_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pos_bad;
    logic       empty;
    logic       full;
    logic       match;
    logic       scan_last;
  } ifls_stat_t;

endpackage

FILE: rtl/core/ifls_ctrl.sv
// Controller state machine sequencing each list operation.
module ifls_ctrl
  import ifls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  ifls_stat_t stat,
  output ifls_cmd_t  cmd,
  output logic       busy,
  output logic       strobe
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_RDWAIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       strobe_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_SEARCH: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          OP_GET: begin
            if (stat.pos_bad) begin
              cmd.finish     = 1'b1;
              cmd.res_status = ST_BAD_POS;
              state_nxt      = S_IDLE;
            end else begin
              cmd.get_rd = 1'b1;
              state_nxt  = S_RDWAIT;
            end
          end
          OP_SET: begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
            if (stat.pos_bad) begin
              cmd.res_status = ST_BAD_POS;
            end else begin
              cmd.set_wr = 1'b1;
            end
          end
          OP_PUSH: begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          OP_POP: begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
            if (stat.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.pop = 1'b1;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.finish    = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = S_IDLE;
        end else if (stat.scan_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RDWAIT: begin
        cmd.finish   = 1'b1;
        cmd.res_read = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= cmd.finish;
    end
  end

  assign busy   = (state_r != S_IDLE);
  assign strobe = strobe_r;

endmodule

FILE: rtl/core/ifls_dpath.sv
// Datapath: ring slot memory, head and count registers, scan walker, result registers.
module ifls_dpath
  import ifls_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ifls_cmd_t           cmd,
  input  logic [2:0]          in_operation,
  input  logic [7:0]          in_position,
  input  logic signed [31:0]  in_value,
  output ifls_stat_t          stat,
  output logic                out_found,
  output logic signed [31:0]  out_read_value,
  output logic [1:0]          out_status,
  output logic [CNT_W-1:0]    out_entry_count
);

  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int SW    = CMP_W + 1;

  logic signed [31:0] mem [DEPTH];

  logic [2:0]         op_r;
  logic [7:0]         pos_r;
  logic signed [31:0] val_r;
  logic [AW-1:0]      head_r;
  logic [AW-1:0]      head_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [AW-1:0]      scan_slot_r;
  logic [CNT_W-1:0]   scan_idx_r;
  logic signed [31:0] rd_data_r;
  logic               found_r;
  logic signed [31:0] read_value_r;
  logic [1:0]         status_r;

  logic [SW-1:0]      pos_sum;
  logic [AW-1:0]      pos_slot;
  logic [AW-1:0]      head_inc;
  logic [AW-1:0]      head_dec;
  logic [AW-1:0]      scan_inc;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;

  assign pos_sum  = SW'(head_r) + SW'(pos_r);
  assign pos_slot = (pos_sum >= SW'(DEPTH)) ? AW'(pos_sum - SW'(DEPTH)) : AW'(pos_sum);

  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign scan_inc = (scan_slot_r == AW'(DEPTH - 1)) ? '0 : scan_slot_r + AW'(1);

  assign stat.op        = op_r;
  assign stat.pos_bad   = (CMP_W'(pos_r) >= CMP_W'(count_r));
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CNT_W'(DEPTH));
  assign stat.match     = (rd_data_r == val_r);
  assign stat.scan_last = (scan_idx_r == count_r);

  always_comb begin
    if (cmd.get_rd) begin
      rd_addr = pos_slot;
    end else if (cmd.scan_start) begin
      rd_addr = head_r;
    end else begin
      rd_addr = scan_slot_r;
    end
  end

  assign rd_en   = cmd.get_rd | cmd.scan_start | cmd.scan_step;
  assign wr_en   = cmd.set_wr | cmd.push;
  assign wr_addr = cmd.push ? head_dec : pos_slot;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.push) begin
      head_nxt  = head_dec;
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.scan_start) begin
      scan_slot_r <= head_inc;
      scan_idx_r  <= CNT_W'(1);
    end else if (cmd.scan_step) begin
      scan_slot_r <= scan_inc;
      scan_idx_r  <= scan_idx_r + CNT_W'(1);
    end
    if (cmd.finish) begin
      found_r      <= cmd.res_found;
      status_r     <= cmd.res_status;
      read_value_r <= cmd.res_read ? rd_data_r : '0;
    end
  end

  assign out_found       = found_r;
  assign out_read_value  = read_value_r;
  assign out_status      = status_r;
  assign out_entry_count = count_r;

endmodule

FILE: rtl/core/indexed_front_list_store.sv
// Indexed front list store: a bounded list of signed 32-bit values kept in a ring memory.
//
// Input: raise start with in_operation, in_position and in_value; the transfer
// happens at a rising edge where start is high and busy is low. Operations are
// search, get, set, push front and pop front; other codes change nothing.
// Output: each transfer yields one result, shown for a single cycle with
// out_strobe high: out_found, out_read_value, out_status, out_entry_count.
// The receiver cannot stall; a result must be taken in its strobe cycle.
// Set, push, pop, unknown codes and every rejected operation finish in the execute
// state; get passes through a read-wait state first. A search that misses visits
// every live entry (an empty list finishes at once); an early hit stops sooner. The
// search walks the live entries through the single read port of the slot memory,
// one entry per cycle.
// busy drops in the strobe cycle, so the next item may enter right away.
// Synchronous reset empties the list (head and count cleared); memory contents
// are left as they are and never read before being written.
module indexed_front_list_store
  import ifls_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_operation,
  input  logic [7:0]                        in_position,
  input  logic signed [31:0]                in_value,
  output logic                              out_strobe,
  output logic                              out_found,
  output logic signed [31:0]                out_read_value,
  output logic [1:0]                        out_status,
  output logic [$clog2(DEPTH + 1)-1:0]      out_entry_count
);

`include "assert_macros.svh"

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ifls_cmd_t  cmd;
  ifls_stat_t stat;

  ifls_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (out_strobe)
  );

  ifls_dpath #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CNT_W (CNT_W)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_value        (in_value),
    .stat            (stat),
    .out_found       (out_found),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  `ASSERT_SAME_CYCLE(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `ASSERT_NEXT_CYCLE(a_accept_busy, clk, rst_n, start && !busy, busy && !out_strobe)
  `ASSERT_SAME_CYCLE(a_count_bound, clk, rst_n, 1'b1, out_entry_count <= CNT_W'(DEPTH))
  `ASSERT_SAME_CYCLE(a_full_count, clk, rst_n, out_strobe && (out_status == ST_FULL), out_entry_count == CNT_W'(DEPTH))
  `ASSERT_SAME_CYCLE(a_found_ok, clk, rst_n, out_strobe && out_found, (out_status == ST_OK) && (out_read_value == 32'sd0))

endmodule

FILE: bench/indexed_front_list_store_monitor.sv
// Monitor that predicts and checks every result of the indexed front list store.
`timescale 1ns / 100ps

module indexed_front_list_store_monitor
  import ifls_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [2:0]                   in_operation,
  input  logic [7:0]                   in_position,
  input  logic signed [31:0]           in_value,
  input  logic                         out_strobe,
  input  logic                         out_found,
  input  logic signed [31:0]           out_read_value,
  input  logic [1:0]                   out_status,
  input  logic [$clog2(DEPTH + 1)-1:0] out_entry_count,
  output int                           error_count,
  output int                           pending
);

  typedef struct packed {
    logic                         found;
    logic [31:0]                  read_value;
    logic [1:0]                   status;
    logic [$clog2(DEPTH + 1)-1:0] entry_count;
  } list_result_t;

  logic [31:0]  slot_mem [DEPTH];
  int           head_slot;
  int           live_count;
  list_result_t expected_results [$];
  list_result_t oldest;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", field, got, want);
    error_count++;
  endtask

  function automatic list_result_t apply_operation(input logic [2:0] op,
                                                   input logic [7:0] pos,
                                                   input logic [31:0] val);
    list_result_t r;
    r = '0;
    case (op)
      OP_SEARCH: begin
        for (int i = 0; i < live_count; i++) begin
          if (slot_mem[(head_slot + i) % DEPTH] == val) r.found = 1'b1;
        end
      end
      OP_GET: begin
        if (int'(pos) >= live_count) r.status = ST_BAD_POS;
        else r.read_value = slot_mem[(head_slot + int'(pos)) % DEPTH];
      end
      OP_SET: begin
        if (int'(pos) >= live_count) r.status = ST_BAD_POS;
        else slot_mem[(head_slot + int'(pos)) % DEPTH] = val;
      end
      OP_PUSH: begin
        if (live_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          slot_mem[head_slot] = val;
          live_count++;
        end
      end
      OP_POP: begin
        if (live_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          head_slot = (head_slot + 1) % DEPTH;
          live_count--;
        end
      end
      default: ;
    endcase
    r.entry_count = live_count[$clog2(DEPTH + 1)-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      head_slot = 0;
      live_count = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transfer pending", 32'd0, 32'd0);
        end else begin
          oldest = expected_results.pop_front();
          if (out_found !== oldest.found)
            report_mismatch("found", out_found, oldest.found);
          if (out_read_value !== oldest.read_value)
            report_mismatch("read_value", out_read_value, oldest.read_value);
          if (out_status !== oldest.status)
            report_mismatch("status", out_status, oldest.status);
          if (out_entry_count !== oldest.entry_count)
            report_mismatch("entry_count", out_entry_count, oldest.entry_count);
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_operation(in_operation, in_position, in_value));
      pending <= expected_results.size();
    end
  end

endmodule

FILE: bench/indexed_front_list_store_test.sv
// Top of the indexed front list store testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module indexed_front_list_store_test;
  import ifls_pkg::*;

  localparam int LIST_DEPTH    = 256;
  localparam int RANDOM_ITEMS  = 750;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [2:0] OP_FIRST_UNUSED = OP_POP + 3'd1;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [2:0]          in_operation = '0;
  logic [7:0]          in_position = '0;
  logic signed [31:0]  in_value = '0;
  logic                busy;
  logic                out_strobe;
  logic                out_found;
  logic signed [31:0]  out_read_value;
  logic [1:0]          out_status;
  logic [8:0]          out_entry_count;
  int                  error_count;
  int                  pending;
  int                  cycle_count = 0;
  int                  list_len = 0;
  logic [31:0]         value_pool [$];

  indexed_front_list_store u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_found       (out_found),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  indexed_front_list_store_monitor #(.DEPTH(LIST_DEPTH)) u_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_found       (out_found),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .error_count     (error_count),
    .pending         (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_gap(input bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7fff_ffff;
        1:       return 32'h8000_0000;
        2:       return 32'hffff_ffff;
        default: return 32'h0000_0000;
      endcase
    end
    if (r < 40 && value_pool.size() > 0)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    return $urandom();
  endfunction

  function automatic logic [7:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (list_len > 0 && r < 70) return 8'($urandom_range(0, list_len - 1));
    if (list_len < LIST_DEPTH && r < 80) return 8'(list_len);
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] pick_operation(input traffic_mode_t mode);
    int r;
    int w_push;
    int w_pop;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin w_push = 85; w_pop = 3;  end
      MODE_DRAIN: begin w_push = 5;  w_pop = 75; end
      default:    begin w_push = 25; w_pop = 25; end
    endcase
    if (r < w_push) return OP_PUSH;
    if (r < w_push + w_pop) return OP_POP;
    if (r >= 97) return OP_FIRST_UNUSED + 3'($urandom_range(0, 2));
    case (r % 3)
      0:       return OP_SEARCH;
      1:       return OP_GET;
      default: return OP_SET;
    endcase
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [7:0] pos,
                           input logic [31:0] val, input int gap);
    start        <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (op)
      OP_PUSH: if (list_len < LIST_DEPTH) list_len++;
      OP_POP:  if (list_len > 0) list_len--;
      default: ;
    endcase
    if (op == OP_PUSH || op == OP_SET) begin
      value_pool.push_back(val);
      if (value_pool.size() > 32) void'(value_pool.pop_front());
    end
    if (gap > 0) begin
      start        <= 1'b0;
      in_operation <= 3'($urandom());
      in_position  <= 8'($urandom());
      in_value     <= $urandom();
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    traffic_mode_t mode;
    int            phase_len;
    int            sent;
    bit            no_idle;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_POP,    8'd0,   32'd0,         pick_gap(0));
    send_item(OP_SEARCH, 8'd0,   32'd0,         pick_gap(0));
    send_item(OP_GET,    8'd0,   32'd0,         pick_gap(0));
    send_item(OP_SET,    8'd0,   32'h5555_aaaa, pick_gap(0));
    send_item(OP_FIRST_UNUSED,        8'hff, 32'hffff_ffff, pick_gap(0));
    send_item(OP_FIRST_UNUSED + 3'd1, 8'd0,  32'd0,         pick_gap(0));
    send_item(OP_FIRST_UNUSED + 3'd2, 8'd1,  32'd1,         pick_gap(0));
    send_item(OP_PUSH,   8'd0,   32'h7fff_ffff, pick_gap(0));
    send_item(OP_PUSH,   8'hff,  32'h8000_0000, pick_gap(0));
    send_item(OP_PUSH,   8'd0,   32'hffff_ffff, pick_gap(0));
    send_item(OP_PUSH,   8'd0,   32'h0000_0000, pick_gap(0));
    send_item(OP_GET,    8'd0,   32'd0,         pick_gap(0));
    send_item(OP_GET,    8'd3,   32'd0,         pick_gap(0));
    send_item(OP_GET,    8'd4,   32'd0,         pick_gap(0));
    send_item(OP_GET,    8'hff,  32'd0,         pick_gap(0));
    send_item(OP_SET,    8'd1,   32'h1234_5678, pick_gap(0));
    send_item(OP_GET,    8'd1,   32'd0,         pick_gap(0));
    send_item(OP_SET,    8'd4,   32'hdead_beef, pick_gap(0));
    send_item(OP_SEARCH, 8'd0,   32'h8000_0000, pick_gap(0));
    send_item(OP_SEARCH, 8'd0,   32'h1234_5678, pick_gap(0));
    send_item(OP_SEARCH, 8'd0,   32'h0000_0005, pick_gap(0));
    send_item(OP_POP,    8'd0,   32'd0,         pick_gap(0));
    send_item(OP_POP,    8'd0,   32'd0,         pick_gap(0));

    sent = 0;
    mode = MODE_FILL;
    phase_len = 340;
    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        send_item(pick_operation(mode), pick_position(), pick_value(), pick_gap(no_idle));
        sent++;
      end
      mode = traffic_mode_t'($urandom_range(0, 2));
      phase_len = $urandom_range(20, 80);
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ifls_pkg.sv
rtl/core/ifls_ctrl.sv
rtl/core/ifls_dpath.sv
rtl/core/indexed_front_list_store.sv
bench/indexed_front_list_store_monitor.sv
bench/indexed_front_list_store_test.sv
